>>> hdl/rrs_pkg.sv
// Shared constants and types for the round-robin schedule simulator.
`timescale 1ns / 1ps
package rrs_pkg;
  localparam int MAX_PROCS_DEF = 16;
  localparam int TW = 24;
  localparam logic [15:0] QUANTUM_RST = 16'd2;

  typedef struct packed {
    logic load;
    logic run_start;
    logic admit_step;
    logic admit_end;
    logic jump;
    logic dispatch;
    logic emit_step;
    logic clear;
  } rrs_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic fifo_empty;
    logic all_done;
    logic emit_last;
    logic full;
  } rrs_stat_t;
endpackage

>>> hdl/rrs_if.sv
// Valid/ready channel interfaces for job requests and results.
`timescale 1ns / 1ps
interface rrs_job_if;
  logic valid;
  logic ready;
  logic [15:0] arrival_time;
  logic [15:0] burst_length;
  logic is_last;
  modport source (output valid, arrival_time, burst_length, is_last, input ready);
  modport sink (input valid, arrival_time, burst_length, is_last, output ready);
endinterface

interface rrs_res_if;
  logic valid;
  logic ready;
  logic [5:0] job_index;
  logic [23:0] completion_time;
  logic [23:0] turnaround_time;
  logic [23:0] waiting_time;
  logic [23:0] response_time;
  logic last_result;
  modport source (output valid, job_index, completion_time, turnaround_time,
                  waiting_time, response_time, last_result, input ready);
  modport sink (input valid, job_index, completion_time, turnaround_time,
                waiting_time, response_time, last_result, output ready);
endinterface

>>> hdl/rrs_datapath.sv
// Job stores, ready queue, time keeping and result formatting.
`timescale 1ns / 1ps
module rrs_datapath #(
  parameter int MAX_PROCS = 16
) (
  input  logic clk,
  input  logic rst,
  input  rrs_pkg::rrs_cmd_t cmd,
  output rrs_pkg::rrs_stat_t stat,
  input  logic [15:0] quantum,
  input  logic [15:0] in_arrival,
  input  logic [15:0] in_burst,
  output logic [5:0] r_index,
  output logic [23:0] r_comp,
  output logic [23:0] r_tat,
  output logic [23:0] r_wait,
  output logic [23:0] r_resp
);
  import rrs_pkg::*;
  localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);

  logic [15:0] arr_mem [MAX_PROCS];
  logic [15:0] bur_mem [MAX_PROCS];
  logic [15:0] rem_mem [MAX_PROCS];
  logic [TW-1:0] comp_mem [MAX_PROCS];
  logic [TW-1:0] resp_mem [MAX_PROCS];
  logic [IW-1:0] fifo [MAX_PROCS];
  logic [MAX_PROCS-1:0] queued, dispatched;
  logic [IW-1:0] head;
  logic [CW-1:0] flen, job_count, done_count, scan;
  logic [TW-1:0] sim_time, earliest;
  logic found;
  logic [IW-1:0] prev_job;
  logic requeue;

  logic [IW-1:0] sidx, cur, tail_pos;
  logic [CW:0] tail_sum;
  logic adm;
  logic [15:0] q, rem;
  logic [TW-1:0] step;

  assign sidx = scan[IW-1:0];
  assign adm = !queued[sidx] && ({8'd0, arr_mem[sidx]} <= sim_time);
  assign q = (quantum == 16'd0) ? 16'd1 : quantum;
  assign cur = fifo[head];
  assign rem = rem_mem[cur];
  assign step = (rem > q) ? {8'd0, q} : {8'd0, rem};
  assign tail_sum = {1'b0, flen} + (CW+1)'(head);
  assign tail_pos = (tail_sum >= (CW+1)'(MAX_PROCS)) ?
                    IW'(tail_sum - (CW+1)'(MAX_PROCS)) : IW'(tail_sum);

  assign stat.scan_last = (scan + CW'(1) >= job_count);
  assign stat.fifo_empty = (flen == '0);
  assign stat.all_done = (done_count >= job_count);
  assign stat.emit_last = (scan + CW'(1) >= job_count);
  assign stat.full = (job_count >= CW'(MAX_PROCS));

  always_ff @(posedge clk) begin
    if (cmd.load && !stat.full) begin
      arr_mem[job_count[IW-1:0]] <= in_arrival;
      bur_mem[job_count[IW-1:0]] <= in_burst;
      rem_mem[job_count[IW-1:0]] <= in_burst;
    end
    if (cmd.admit_step && adm) fifo[tail_pos] <= sidx;
    if (cmd.admit_end && requeue) fifo[tail_pos] <= prev_job;
    if (cmd.dispatch) begin
      if (!dispatched[cur]) resp_mem[cur] <= sim_time - {8'd0, arr_mem[cur]};
      rem_mem[cur] <= rem - step[15:0];
      if (rem <= q) comp_mem[cur] <= sim_time + step;
    end
    r_index <= 6'(scan);
    r_comp <= comp_mem[sidx];
    r_tat <= comp_mem[sidx] - {8'd0, arr_mem[sidx]};
    r_wait <= comp_mem[sidx] - {8'd0, arr_mem[sidx]} - {8'd0, bur_mem[sidx]};
    r_resp <= resp_mem[sidx];
  end

  // admit_end re-queues the preempted job once the admission scan is over
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      queued <= '0; dispatched <= '0; head <= '0; flen <= '0;
      job_count <= '0; done_count <= '0; scan <= '0; sim_time <= '0;
      earliest <= '0; found <= 1'b0; prev_job <= '0; requeue <= 1'b0;
    end else begin
      if (cmd.load && !stat.full) begin
        queued[job_count[IW-1:0]] <= 1'b0;
        dispatched[job_count[IW-1:0]] <= 1'b0;
        job_count <= job_count + CW'(1);
      end
      if (cmd.run_start) begin
        scan <= '0; found <= 1'b0;
      end
      if (cmd.admit_step) begin
        if (adm) begin
          queued[sidx] <= 1'b1;
          flen <= flen + CW'(1);
        end
        if (!queued[sidx] && !adm && (!found || {8'd0, arr_mem[sidx]} < earliest)) begin
          earliest <= {8'd0, arr_mem[sidx]};
          found <= 1'b1;
        end
        scan <= stat.scan_last ? '0 : scan + CW'(1);
      end
      if (cmd.jump) begin
        if (found && earliest > sim_time) sim_time <= earliest;
        found <= 1'b0;
        scan <= '0;
      end
      if (cmd.admit_end) begin
        if (requeue) flen <= flen + CW'(1);
      end
      if (cmd.dispatch) begin
        dispatched[cur] <= 1'b1;
        prev_job <= cur;
        requeue <= (rem > q);
        head <= (head == IW'(MAX_PROCS - 1)) ? '0 : head + IW'(1);
        flen <= flen - CW'(1);
        sim_time <= sim_time + step;
        if (rem <= q) done_count <= done_count + CW'(1);
        scan <= '0; found <= 1'b0;
      end
      if (cmd.emit_step) scan <= scan + CW'(1);
    end
  end
endmodule

>>> hdl/rrs_ctrl.sv
// Sequencer for loading, scheduling and result delivery.
`timescale 1ns / 1ps
module rrs_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_last,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output logic out_last,
  output rrs_pkg::rrs_cmd_t cmd,
  input  rrs_pkg::rrs_stat_t stat
);
  import rrs_pkg::*;
  localparam logic [2:0] S_LOAD = 3'd0, S_ADMIT = 3'd1, S_DECIDE = 3'd2,
    S_RUN = 3'd3, S_FETCH = 3'd5, S_SHOW = 3'd6;
  logic [2:0] state, state_next;
  logic from_run, from_run_next, lst, lst_next;

  assign in_ready = (state == S_LOAD);
  assign out_valid = (state == S_SHOW);
  assign out_last = lst;

  always_comb begin
    cmd = '0;
    state_next = state;
    from_run_next = from_run;
    lst_next = lst;
    case (state)
      S_LOAD: if (in_valid) begin
        cmd.load = 1'b1;
        if (in_last) begin
          cmd.run_start = 1'b1; from_run_next = 1'b0; state_next = S_ADMIT;
        end
      end
      S_ADMIT: begin
        cmd.admit_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (from_run) begin
          cmd.admit_end = 1'b1; from_run_next = 1'b0; state_next = S_RUN;
        end else if (stat.all_done) begin
          state_next = S_FETCH;
        end else if (stat.fifo_empty) begin
          cmd.jump = 1'b1; state_next = S_ADMIT;
        end else begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (stat.all_done) state_next = S_FETCH;
        else if (stat.fifo_empty) begin
          cmd.jump = 1'b1; state_next = S_ADMIT;
        end else begin
          cmd.dispatch = 1'b1; from_run_next = 1'b1; state_next = S_ADMIT;
        end
      end
      S_FETCH: begin
        lst_next = stat.emit_last; state_next = S_SHOW;
      end
      S_SHOW: if (out_ready) begin
        if (lst) begin
          cmd.clear = 1'b1; state_next = S_LOAD;
        end else begin
          cmd.emit_step = 1'b1; state_next = S_FETCH;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD; from_run <= 1'b0; lst <= 1'b0;
    end else begin
      state <= state_next; from_run <= from_run_next; lst <= lst_next;
    end
  end
endmodule

>>> hdl/round_robin_schedule_sim.sv
// Top level of the round-robin schedule simulator.
//  channel  dir  payload
//  job      in   arrival_time, burst_length, is_last
//  res      out  job_index, completion/turnaround/waiting/response times, last_result
// Jobs load one a cycle while in_ready is high. Each dispatch and each queue-empty
// time jump is followed by an admission pass that walks every loaded job; results are
// then fetched and shown one at a time. Reset is synchronous; a stalled result holds,
// and no job request is taken until the last result of the set has gone.
`timescale 1ns / 1ps
module round_robin_schedule_sim #(
  parameter int MAX_PROCS = rrs_pkg::MAX_PROCS_DEF
) (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [15:0] cfg_wdata,
  rrs_job_if.sink job,
  rrs_res_if.source res
);
  import rrs_pkg::*;
  logic [15:0] quantum;
  rrs_cmd_t cmd;
  rrs_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) quantum <= QUANTUM_RST;
    else if (cfg_we) quantum <= cfg_wdata;
  end

  rrs_ctrl u_ctrl (
    .clk, .rst, .in_valid(job.valid), .in_last(job.is_last), .in_ready(job.ready),
    .out_valid(res.valid), .out_ready(res.ready), .out_last(res.last_result),
    .cmd, .stat
  );

  rrs_datapath #(.MAX_PROCS(MAX_PROCS)) u_dp (
    .clk, .rst, .cmd, .stat, .quantum,
    .in_arrival(job.arrival_time), .in_burst(job.burst_length),
    .r_index(res.job_index), .r_comp(res.completion_time),
    .r_tat(res.turnaround_time), .r_wait(res.waiting_time),
    .r_resp(res.response_time)
  );
endmodule

>>> tb/tb_round_robin_schedule_sim.sv
// Self-checking testbench for the round-robin schedule simulator.
`timescale 1ns / 1ps
module tb_round_robin_schedule_sim;
  import rrs_pkg::*;

  localparam int NPROC = MAX_PROCS_DEF;
  localparam logic [23:0] M24 = 24'hFFFFFF;

  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] burst;
    logic last;
  } job_req_t;

  typedef struct packed {
    logic [5:0] idx;
    logic [23:0] comp;
    logic [23:0] tat;
    logic [23:0] wait_t;
    logic [23:0] resp;
    logic last;
  } job_stat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  rrs_job_if job ();
  rrs_res_if res ();

  round_robin_schedule_sim uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .job(job.sink), .res(res.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  job_req_t pending_jobs[$];
  job_stat_t expected_stats[$];
  logic [15:0] quantum = QUANTUM_RST;
  int errors = 0;
  int jobs_sent = 0;
  int sets_run = 0;
  int stats_seen = 0;
  bit quiet = 1'b0;

  // scheduler mirror for the set being loaded
  logic [15:0] arr_m[NPROC];
  logic [15:0] bur_m[NPROC];
  int loaded = 0;

  task automatic run_set();
    logic [23:0] now;
    logic [23:0] rem[NPROC];
    logic [23:0] comp[NPROC];
    logic [23:0] resp[NPROC];
    logic [23:0] q;
    logic [23:0] earliest;
    logic [23:0] tat;
    bit queued[NPROC];
    bit disp[NPROC];
    int fifo[$];
    int done;
    int i;
    bit found;
    job_stat_t s;
    q = (quantum == 0) ? 24'd1 : {8'd0, quantum};
    now = 0;
    done = 0;
    i = -1;
    for (int j = 0; j < loaded; j++) begin
      rem[j] = {8'd0, bur_m[j]};
      queued[j] = 0;
      disp[j] = 0;
    end
    for (int j = 0; j < loaded; j++)
      if (!queued[j] && arr_m[j] <= now) begin queued[j] = 1; fifo.push_back(j); end
    while (done < loaded) begin
      if (fifo.size() == 0) begin
        found = 0;
        earliest = 0;
        for (int j = 0; j < loaded; j++)
          if (!queued[j] && (!found || arr_m[j] < earliest)) begin
            earliest = arr_m[j];
            found = 1;
          end
        if (!found) break;
        if (earliest > now) now = earliest;
      end else begin
        i = fifo.pop_front();
        if (!disp[i]) begin resp[i] = (now - arr_m[i]) & M24; disp[i] = 1; end
        if (rem[i] > q) begin
          now = (now + q) & M24;
          rem[i] -= q;
        end else begin
          now = (now + rem[i]) & M24;
          rem[i] = 0;
          comp[i] = now;
          done++;
        end
      end
      for (int j = 0; j < loaded; j++)
        if (!queued[j] && arr_m[j] <= now) begin queued[j] = 1; fifo.push_back(j); end
      if (i >= 0 && rem[i] > 0) fifo.push_back(i);
      i = -1;
    end
    for (int j = 0; j < loaded; j++) begin
      tat = (comp[j] - arr_m[j]) & M24;
      s.idx = j[5:0];
      s.comp = comp[j];
      s.tat = tat;
      s.wait_t = (tat - bur_m[j]) & M24;
      s.resp = resp[j];
      s.last = (j + 1 == loaded);
      expected_stats.push_back(s);
    end
    loaded = 0;
    sets_run++;
  endtask

  task automatic predict_job(input job_req_t r);
    if (loaded < NPROC) begin
      arr_m[loaded] = r.arrival;
      bur_m[loaded] = r.burst;
      loaded++;
    end
    if (r.last) run_set();
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      job.valid <= 1'b0;
    end else begin
      if (job.valid && job.ready) begin
        jobs_sent++;
        predict_job({job.arrival_time, job.burst_length, job.is_last});
      end
      if (!job.valid || job.ready) begin
        if (pending_jobs.size() > 0 && (quiet || $urandom_range(99) >= 18)) begin
          job.valid <= 1'b1;
          {job.arrival_time, job.burst_length, job.is_last} <= pending_jobs.pop_front();
        end else begin
          job.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    job_stat_t got;
    job_stat_t want;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        got = {res.job_index, res.completion_time, res.turnaround_time,
               res.waiting_time, res.response_time, res.last_result};
        stats_seen++;
        if (expected_stats.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_stats.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
      res.ready <= quiet || ($urandom_range(99) >= 18);
    end
  end

  initial begin
    job.valid = 1'b0;
    job.arrival_time = '0;
    job.burst_length = '0;
    job.is_last = 1'b0;
    res.ready = 1'b0;
  end

  function automatic job_req_t mk(input int a, input int b, input bit l);
    mk.arrival = a[15:0];
    mk.burst = b[15:0];
    mk.last = l;
  endfunction

  task automatic drain();
    while (pending_jobs.size() > 0 || job.valid || expected_stats.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_quantum(input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    quantum = v;
  endtask

  task automatic random_sets(input int count, input int amax, input int bmax);
    int n;
    for (int s = 0; s < count; s++) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(NPROC + 2, 17) : $urandom_range(6, 1);
      for (int k = 0; k < n; k++)
        pending_jobs.push_back(mk($urandom_range(amax), $urandom_range(bmax, 1), k == n - 1));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // reset quantum, out-of-order arrivals, idle gap, zero burst
    pending_jobs.push_back(mk(5, 3, 0));
    pending_jobs.push_back(mk(0, 4, 0));
    pending_jobs.push_back(mk(0, 0, 0));
    pending_jobs.push_back(mk(40, 1, 1));
    pending_jobs.push_back(mk(65535, 65535, 1));
    pending_jobs.push_back(mk(0, 65535, 0));
    pending_jobs.push_back(mk(65535, 1, 1));
    drain();
    set_quantum(16'd0);
    pending_jobs.push_back(mk(0, 3, 0));
    pending_jobs.push_back(mk(1, 2, 1));
    // overfull set, last marked on a dropped request
    for (int k = 0; k < NPROC + 2; k++)
      pending_jobs.push_back(mk(k * 3, k + 1, k == NPROC + 1));
    drain();
    set_quantum(16'hFFFF);
    pending_jobs.push_back(mk(2, 65535, 0));
    pending_jobs.push_back(mk(0, 7, 1));
    random_sets(6, 65535, 65535);
    drain();
    set_quantum(16'd1);
    random_sets(15, 20, 8);
    drain();
    set_quantum(16'd3);
    quiet = 1'b1;
    random_sets(15, 30, 12);
    drain();
    quiet = 1'b0;
    // keep long bursts to a bounded number of slices
    set_quantum(16'($urandom_range(65535, 4096)));
    random_sets(15, 65535, 65535);
    drain();
    $display("Ran %0d job requests in %0d sets, %0d results checked.",
             jobs_sent, sets_run, stats_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

>>> files.f
hdl/rrs_pkg.sv
hdl/rrs_if.sv
hdl/rrs_datapath.sv
hdl/rrs_ctrl.sv
hdl/round_robin_schedule_sim.sv
tb/tb_round_robin_schedule_sim.sv
